FILE: src/cq_pkg.sv
// ----------------------------------------------------------------------------
// cq_pkg: shared types and constants for the circular queue
// Holds the field widths, operation codes and the command bundle that the
// controller drives into the datapath.
// ----------------------------------------------------------------------------
package cq_pkg;

   // built number of slots unless the top level is told otherwise
   localparam int DEPTH_DEFAULT = 16;

   // field widths
   localparam int OP_W   = 2;
   localparam int WORD_W = 32;
   localparam int CAP_W  = 5;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // word reported for front and rear of an empty queue
   localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

   // operation codes; the unused code acts as a query
   typedef enum logic [OP_W-1:0] {
      OP_ENQ   = 2'd0,
      OP_DEQ   = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   // controller commands to the datapath
   typedef struct packed {
      logic exec;   // request transfer: apply the operation this cycle
      logic load;   // capture slot reads and flags for the response
   } cmd_type;

endpackage

FILE: src/circular_queue.sv
// ----------------------------------------------------------------------------
// circular_queue: ring-buffer queue of signed 32-bit words
// Enqueue, dequeue or query per request; one response per request with the
// outcome, front and rear words and the empty and full flags.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   op, value
//   rsp      out        rsp_tvalid/rsp_tready   ok, front, rear, empty, full
//   csr      in         csr_valid/csr_ready     capacity
//
// A request is applied and its slot written at its transfer edge. The next
// edge reads front and rear from the slot memory and raises rsp_tvalid.
// One request is in flight; the next is taken the cycle after the response
// transfer. Reset empties the queue and sets capacity to 16.
// ----------------------------------------------------------------------------
module circular_queue
   import cq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // op[1:0], value[33:2]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // ok[0], front_word[32:1],
                                               // rear_word[64:33],
                                               // empty_flag[65], full_flag[66]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CAP_W-1:0]       csr_wdata
);

   cmd_type                  cmd;
   logic                     ok;
   logic signed [WORD_W-1:0] front_word;
   logic signed [WORD_W-1:0] rear_word;
   logic                     empty_flag;
   logic                     full_flag;

   // capacity writes are always taken
   assign csr_ready = 1'b1;

   cq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .ok         (ok),
      .front_word (front_word),
      .rear_word  (rear_word),
      .empty_flag (empty_flag),
      .full_flag  (full_flag)
   );

   // pack the response fields, lowest first
   assign rsp_tdata = {5'b0, full_flag, empty_flag, rear_word, front_word, ok};

endmodule

FILE: src/cq_ctrl.sv
// ----------------------------------------------------------------------------
// cq_ctrl: sequencing of the circular queue
// Takes one request, lets the datapath read the slots, then holds the
// response until it is taken.
// ----------------------------------------------------------------------------
module cq_ctrl
   import cq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      req_tready_ff;
   logic      rsp_tvalid_ff;
   logic      load_ff;

   // request transfer applies the operation at once
   assign cmd.exec   = req_tvalid & req_tready_ff;
   assign cmd.load   = load_ff;
   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   // advance state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
         load_ff       <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               load_ff <= 1'b0;
               if (req_tvalid && req_tready_ff) begin
                  state_ff      <= S_READ;
                  req_tready_ff <= 1'b0;
                  load_ff       <= 1'b1;
               end
            end
            S_READ: begin
               load_ff       <= 1'b0;
               rsp_tvalid_ff <= 1'b1;
               state_ff      <= S_RESP;
            end
            S_RESP: begin
               load_ff <= 1'b0;
               if (rsp_tready) begin
                  rsp_tvalid_ff <= 1'b0;
                  req_tready_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff      <= S_IDLE;
               req_tready_ff <= 1'b1;
               rsp_tvalid_ff <= 1'b0;
               load_ff       <= 1'b0;
            end
         endcase
      end
   end

   // every applied operation is followed by the slot read
   a_exec_then_load: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> cmd.load)
      else $error("slot read did not follow an applied operation");

   // no new request while a response is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !req_tready_ff)
      else $error("request taken while a response is pending");

endmodule

FILE: src/cq_datapath.sv
// ----------------------------------------------------------------------------
// cq_datapath: slot memory, indices and flags of the circular queue
// Applies one operation on command, then reads the front and rear slots
// into registers for the response.
// ----------------------------------------------------------------------------
module cq_datapath
   import cq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   input  logic                    csr_valid,
   input  logic [CAP_W-1:0]        csr_wdata,
   output logic                    ok,
   output logic signed [WORD_W-1:0] front_word,
   output logic signed [WORD_W-1:0] rear_word,
   output logic                    empty_flag,
   output logic                    full_flag
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ACAP_W = $clog2(DEPTH + 1);

   logic [WORD_W-1:0] mem [DEPTH];

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic              ok_ff, ok_in;
   logic              full_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [WORD_W-1:0] front_rd_ff;
   logic [WORD_W-1:0] rear_rd_ff;

   logic [ACAP_W-1:0] acap;
   logic [IDX_W:0]    head_inc;
   logic [IDX_W:0]    tail_inc;
   logic [IDX_W-1:0]  head_next;
   logic [IDX_W-1:0]  tail_next;
   logic              full_now;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   op_type            op;
   logic [WORD_W-1:0] value;

   assign op    = op_type'(req_tdata[OP_W-1:0]);
   assign value = req_tdata[OP_W+WORD_W-1:OP_W];

   // clamp capacity into 1..DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         acap = ACAP_W'(1);
      end else if (32'(cap_ff) > DEPTH) begin
         acap = ACAP_W'(DEPTH);
      end else begin
         acap = ACAP_W'(cap_ff);
      end
   end

   // step indices with compare-and-wrap at capacity
   always_comb begin
      head_inc  = {1'b0, head_ff} + 1'b1;
      tail_inc  = {1'b0, tail_ff} + 1'b1;
      head_next = (32'(head_inc) >= 32'(acap)) ? '0 : head_inc[IDX_W-1:0];
      tail_next = (32'(tail_inc) >= 32'(acap)) ? '0 : tail_inc[IDX_W-1:0];
      full_now  = !empty_ff && (tail_next == head_ff);
   end

   // apply the operation
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      ok_in    = ok_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_next;
      if (cmd.exec) begin
         ok_in = 1'b1;
         case (op)
            OP_ENQ: begin
               if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  wr_en    = 1'b1;
                  wr_addr  = '0;
               end else if (!full_now) begin
                  tail_in = tail_next;
                  wr_en   = 1'b1;
               end else begin
                  ok_in = 1'b0;
               end
            end
            OP_DEQ: begin
               if (empty_ff) begin
                  ok_in = 1'b0;
               end else if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
                  head_in  = '0;
                  tail_in  = '0;
               end else begin
                  head_in = head_next;
               end
            end
            default: begin
               ok_in = 1'b1;
            end
         endcase
      end
   end

   // hold indices, the empty flag and capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         cap_ff   <= CAP_RESET;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         if (csr_valid) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // write the slot, read front and rear for the response
   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
      if (wr_en) begin
         mem[wr_addr] <= value;
      end
      if (cmd.load) begin
         front_rd_ff <= mem[head_ff];
         rear_rd_ff  <= mem[tail_ff];
         full_ff     <= full_now;
      end
   end

   assign ok         = ok_ff;
   assign empty_flag = empty_ff;
   assign full_flag  = full_ff;
   assign front_word = empty_ff ? EMPTY_WORD : front_rd_ff;
   assign rear_word  = empty_ff ? EMPTY_WORD : rear_rd_ff;

   // an empty queue keeps both indices at the first slot
   a_empty_idx: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with nonzero index");

   // a failed operation leaves the queue untouched
   a_fail_stable: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !ok_in) |=> (head_ff == $past(head_ff) && tail_ff == $past(tail_ff)
                                && empty_ff == $past(empty_ff)))
      else $error("failed operation changed the queue");

endmodule
